// ===== sv/sorted_key_table_search_insert_unit_macros.svh =====
// Assertion macros used by the sorted key table top level.
`ifndef SORTED_KEY_TABLE_SEARCH_INSERT_UNIT_MACROS_SVH
`define SORTED_KEY_TABLE_SEARCH_INSERT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SKST_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SKST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/skst_pkg.sv =====
// Shared types, constants and codes for the sorted key table.
package skst_pkg;

  localparam int SKST_DEPTH = 64;
  localparam int KEY_W      = 16;
  localparam int OUT_W      = 7;
  localparam int STATUS_W   = 2;

  // request types
  localparam logic REQ_SEARCH = 1'b0;
  localparam logic REQ_INSERT = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_DUP  = 2'd2;

  // what one cell hands to its upper neighbor
  typedef struct packed {
    logic             valid;
    logic             lt;
    logic             eq;
    logic             at_pos;
    logic [KEY_W-1:0] key;
  } cell_link_t;

  // common control broadcast to all cells
  typedef struct packed {
    logic             upd;
    logic [KEY_W-1:0] key;
  } cell_ctrl_t;

endpackage

// ===== sv/skst_cell.sv =====
// One table cell: holds a key, compares it and shifts up on insert.
module skst_cell
  import skst_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cell_link_t prev,
  output cell_link_t link
);

  logic             valid_r, valid_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic             lt, eq, at_pos;

  // compare the stored key against the request key
  assign lt     = valid_r && (key_r < ctrl.key);
  assign eq     = valid_r && (key_r == ctrl.key);
  assign at_pos = prev.lt && !lt;

  // take the new key at the slot, take the lower neighbor above it, else hold
  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    if (ctrl.upd) begin
      if (at_pos) begin
        valid_nxt = 1'b1;
        key_nxt   = ctrl.key;
      end else if (!prev.lt) begin
        valid_nxt = prev.valid;
        key_nxt   = prev.key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign link.valid  = valid_r;
  assign link.lt     = lt;
  assign link.eq     = eq;
  assign link.at_pos = at_pos;
  assign link.key    = key_r;

endmodule

// ===== sv/skst_pos_enc.sv =====
// One-hot to binary encoder for the insertion slot.
module skst_pos_enc
  import skst_pkg::*;
#(
  parameter int DEPTH = SKST_DEPTH,
  localparam int PW   = $clog2(DEPTH + 1)
) (
  input  logic [DEPTH:0]  onehot,
  output logic [PW-1:0]   pos
);

  // OR together the indexes of the set bits
  always_comb begin
    pos = '0;
    for (int i = 0; i <= DEPTH; i++) begin
      if (onehot[i]) begin
        pos = pos | PW'(i);
      end
    end
  end

endmodule

// ===== sv/sorted_key_table_search_insert_unit.sv =====
// Top level of the sorted key table with search and in-order insert.
//
//   channel  | handshake               | beat
//   ---------+-------------------------+--------------------------------------
//   request  | start & !busy           | in_req_type, in_req_key
//   result   | out_valid (one cycle)   | out_key_found, out_position,
//            |                         | out_status, out_count_after
//
// A request is registered at the accept edge, and in the next
// cycle every cell compares in parallel, the slot is encoded and an insert
// shifts the row; the result beat shows in the cycle after that.
// busy is high for that one compare cycle, so a new request can be taken in
// the same cycle as the result beat. Synchronous reset empties the table at once (valid bits and
// count clear); the receiver cannot stall the result.
module sorted_key_table_search_insert_unit
  import skst_pkg::*;
#(
  parameter int TABLE_DEPTH = SKST_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic                in_req_type,
  input  logic [KEY_W-1:0]    in_req_key,
  output logic                out_valid,
  output logic                out_key_found,
  output logic [OUT_W-1:0]    out_position,
  output logic [STATUS_W-1:0] out_status,
  output logic [OUT_W-1:0]    out_count_after
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic                busy_r;
  logic                type_r;
  logic [KEY_W-1:0]    key_r;
  logic [CW-1:0]       count_r, count_nxt;
  logic                out_valid_r;
  logic                found_out_r;
  logic [OUT_W-1:0]    pos_out_r;
  logic [STATUS_W-1:0] status_out_r, status_nxt;
  logic [OUT_W-1:0]    count_out_r;

  cell_ctrl_t            ctrl;
  cell_link_t            links [TABLE_DEPTH];
  cell_link_t            base;
  logic [TABLE_DEPTH:0]  onehot;
  logic [TABLE_DEPTH-1:0] eq_vec;
  logic [CW-1:0]         pos;
  logic                  found, full, do_ins, accept;

  assign accept = start && !busy_r;

  // register the request beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      type_r <= in_req_type;
      key_r  <= in_req_key;
    end
  end

  // the cell below cell 0 always counts as smaller than the key
  assign base.valid  = 1'b1;
  assign base.lt     = 1'b1;
  assign base.eq     = 1'b0;
  assign base.at_pos = 1'b0;
  assign base.key    = '0;

  assign ctrl.upd = busy_r && do_ins;
  assign ctrl.key = key_r;

  // row of cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    if (g == 0) begin : g_first
      skst_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .prev  (base),
        .link  (links[g])
      );
    end else begin : g_rest
      skst_cell u_cell (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .prev  (links[g-1]),
        .link  (links[g])
      );
    end
    assign onehot[g] = links[g].at_pos;
    assign eq_vec[g] = links[g].eq;
  end

  // every entry below the key: the slot is past the last cell
  assign onehot[TABLE_DEPTH] = links[TABLE_DEPTH-1].lt;

  skst_pos_enc #(
    .DEPTH (TABLE_DEPTH)
  ) u_pos_enc (
    .onehot (onehot),
    .pos    (pos)
  );

  assign found  = |eq_vec;
  assign full   = (count_r == CW'(TABLE_DEPTH));
  assign do_ins = (type_r == REQ_INSERT) && !found && !full;

  // decide status and new count
  always_comb begin
    status_nxt = ST_OK;
    if (type_r == REQ_INSERT) begin
      if (found) begin
        status_nxt = ST_DUP;
      end else if (full) begin
        status_nxt = ST_FULL;
      end
    end
    count_nxt = do_ins ? count_r + CW'(1) : count_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= busy_r;
      if (busy_r) begin
        count_r <= count_nxt;
      end
    end
  end

  // hold the result beat
  always_ff @(posedge clk) begin
    if (busy_r) begin
      found_out_r  <= found;
      pos_out_r    <= OUT_W'(pos);
      status_out_r <= status_nxt;
      count_out_r  <= OUT_W'(count_nxt);
    end
  end

  assign busy            = busy_r;
  assign out_valid       = out_valid_r;
  assign out_key_found   = found_out_r;
  assign out_position    = pos_out_r;
  assign out_status      = status_out_r;
  assign out_count_after = count_out_r;

`include "sorted_key_table_search_insert_unit_macros.svh"

  `SKST_ASSERT_NEXT(a_busy_gives_result, busy_r, out_valid_r, "compare cycle gave no result")
  `SKST_ASSERT_NOW(a_no_overlap, busy_r, !out_valid_r, "result beat overlaps compare cycle")
  `SKST_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CW'(TABLE_DEPTH), "entry count past depth")
  `SKST_ASSERT_NOW(a_dup_found, out_valid_r && (status_out_r == ST_DUP), found_out_r, "duplicate without match")

endmodule
